### rtl/core/mrt_pkg.sv
`default_nettype none
package mrt_pkg;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_BAD_LEN    = 4'd1,
        ST_UNALIGNED  = 4'd2,
        ST_NO_FILE    = 4'd3,
        ST_UNREADABLE = 4'd4,
        ST_UNWRITABLE = 4'd5,
        ST_FULL       = 4'd6,
        ST_BAD_UNMAP  = 4'd7,
        ST_NOT_MAPPED = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        PA_NONE  = 2'd0,
        PA_WBACK = 2'd1,
        PA_DROP  = 2'd2,
        PA_FREE  = 2'd3
    } t_page_action;

    localparam logic [63:0] MAP_BASE   = 64'h0000_0000_6000_0000;
    localparam logic [2:0]  FL_SHARED  = 3'h1;
    localparam logic [2:0]  FL_PRIVATE = 3'h2;
    localparam logic [2:0]  FL_ANON    = 3'h4;
    localparam logic [2:0]  PR_READ    = 3'h1;
    localparam logic [2:0]  PR_WRITE   = 3'h2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clear;
        logic step;
        logic commit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic pre_fail;
    } t_dp_sts;

endpackage
`default_nettype wire

### rtl/core/mrt_ctrl.sv
`default_nettype none
module mrt_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output mrt_pkg::t_dp_cmd     o_cmd,
    input  wire mrt_pkg::t_dp_sts i_sts
);
    import mrt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE, S_OUT} t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.clear = (r_state == S_SCAN) && i_sts.pre_fail;
        o_cmd.step  = (r_state == S_SCAN) && !i_sts.pre_fail;
        o_cmd.commit = (r_state == S_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (i_sts.pre_fail) begin
                        r_state     <= S_OUT;
                        r_out_valid <= 1'b1;
                    end else if (i_sts.scan_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_state     <= S_OUT;
                    r_out_valid <= 1'b1;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_state == S_OUT) else $error("result shown outside S_OUT");
    a_done_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE |-> $past(r_state) == S_SCAN) else $error("bad entry to S_DONE");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !r_out_valid) else $error("load while result pending");
`endif
endmodule
`default_nettype wire

### rtl/core/mrt_dp.sv
`default_nettype none
module mrt_dp #(
    parameter int SLOTS      = 16,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mrt_pkg::t_dp_cmd i_cmd,
    output mrt_pkg::t_dp_sts      o_sts,
    input  wire logic             i_operation,
    input  wire logic [63:0]      i_address,
    input  wire logic [31:0]      i_length,
    input  wire logic [2:0]       i_protection,
    input  wire logic [2:0]       i_map_flags,
    input  wire logic             i_no_descriptor,
    input  wire logic             i_file_present,
    input  wire logic             i_file_readable,
    input  wire logic             i_file_writable,
    input  wire logic [7:0]       i_file_handle,
    input  wire logic [31:0]      i_file_offset,
    output logic [3:0]            o_status,
    output logic [63:0]           o_region_address,
    output logic [63:0]           o_range_end,
    output logic [3:0]            o_slot,
    output logic [1:0]            o_page_action,
    output logic [7:0]            o_entry_file,
    output logic [31:0]           o_entry_file_offset,
    output logic                  o_take_file_ref,
    output logic                  o_release_file
);
    import mrt_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int PB = $clog2(PAGE_BYTES);

    logic [SLOTS-1:0] r_used;
    logic [63:0] m_start  [SLOTS];
    logic [31:0] m_len    [SLOTS];
    logic [2:0]  m_prot   [SLOTS];
    logic [2:0]  m_flags  [SLOTS];
    logic        m_hasf   [SLOTS];
    logic [7:0]  m_file   [SLOTS];
    logic [31:0] m_off    [SLOTS];

    logic        r_op, r_anon;
    logic [63:0] r_addr;
    logic [31:0] r_off, r_alen;
    logic [2:0]  r_prot, r_flags;
    logic [7:0]  r_fh;
    logic [3:0]  r_pre;
    logic        r_len_ovf;
    logic [CW-1:0] r_idx;
    logic        r_found;
    logic [SW-1:0] r_hit;
    logic [63:0] r_va;

    // request pre-check
    logic        n_anon;
    logic [3:0]  n_pre;
    logic [31:0] n_mag;
    always_comb begin
        n_anon = i_no_descriptor || i_map_flags[2];
        n_mag  = i_file_offset[31] ? (32'd0 - i_file_offset) : i_file_offset;
        n_pre  = ST_OK;
        if (i_operation) begin
            if (i_length[31] || i_length == 32'd0 || i_address[PB-1:0] != '0)
                n_pre = ST_BAD_UNMAP;
        end else if (i_length[31] || i_length == 32'd0) begin
            n_pre = ST_BAD_LEN;
        end else if (!n_anon) begin
            if (n_mag[PB-1:0] != '0) n_pre = ST_UNALIGNED;
            else if (!i_file_present) n_pre = ST_NO_FILE;
            else if ((i_protection & PR_READ) != 0 && !i_file_readable)
                n_pre = ST_UNREADABLE;
            else if ((i_protection & PR_WRITE) != 0 && (i_map_flags & FL_SHARED) != 0
                     && !i_file_writable)
                n_pre = ST_UNWRITABLE;
        end
    end

    // page-rounded request length, 33 bits to see overflow
    logic [32:0] w_rl;
    assign w_rl = ({1'b0, i_length} + 33'(PAGE_BYTES - 1)) & ~33'(PAGE_BYTES - 1);

    // scan element
    logic [SW-1:0] w_i;
    logic [63:0]   w_end, w_end_up;
    logic          w_cur_used;
    assign w_i        = r_idx[SW-1:0];
    assign w_cur_used = r_used[w_i];
    assign w_end      = m_start[w_i] + {32'd0, m_len[w_i]};
    assign w_end_up   = (w_end + 64'(PAGE_BYTES - 1)) & ~64'(PAGE_BYTES - 1);

    assign o_sts.scan_done = (r_idx == CW'(SLOTS));
    assign o_sts.pre_fail  = (r_pre != ST_OK) && (r_idx == '0);

    // unmap arithmetic on the hit slot
    logic [63:0] u_start, u_vend, u_end, u_cut;
    logic [2:0]  u_fl, u_pr;
    logic        u_hf;
    logic [1:0]  u_act;
    logic        u_whole;
    logic [3:0]  u_fail;
    always_comb begin
        u_start = m_start[r_hit];
        u_vend  = u_start + {32'd0, m_len[r_hit]};
        u_end   = ({32'd0, r_alen} >= (u_vend - r_addr)) ? u_vend
                  : r_addr + {32'd0, r_alen};
        u_cut   = u_end - r_addr;
        u_whole = (r_addr == u_start) && (u_end == u_vend);
        u_fl = m_flags[r_hit];
        u_pr = m_prot[r_hit];
        u_hf = m_hasf[r_hit];
        if ((u_fl & FL_SHARED) != 0 && (u_pr & PR_WRITE) != 0 && u_hf) u_act = PA_WBACK;
        else if ((u_fl & FL_PRIVATE) != 0 && u_hf) u_act = PA_DROP;
        else if ((u_fl & FL_ANON) != 0) u_act = PA_FREE;
        else u_act = PA_NONE;
        if (r_op) u_fail = ST_NOT_MAPPED;
        else if (!r_found) u_fail = ST_FULL;
        else u_fail = ST_BAD_LEN;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_anon  <= n_anon;
            r_addr  <= i_address;
            r_off   <= n_anon ? 32'd0 : i_file_offset;
            r_prot  <= i_protection;
            r_flags <= n_anon ? (i_map_flags | FL_ANON) : i_map_flags;
            r_fh    <= n_anon ? 8'd0 : i_file_handle;
            r_pre   <= n_pre;
            r_alen  <= w_rl[32] ? 32'hffff_ffff : w_rl[31:0];
            r_len_ovf <= w_rl[32] || w_rl[31];
            r_idx   <= '0;
            r_found <= 1'b0;
            r_hit   <= '0;
            r_va    <= MAP_BASE;
        end
        if (i_cmd.clear) begin
            o_status <= r_pre;
            o_region_address <= '0;
            o_range_end <= '0;
            o_slot <= '0;
            o_page_action <= '0;
            o_entry_file <= '0;
            o_entry_file_offset <= '0;
            o_take_file_ref <= 1'b0;
            o_release_file <= 1'b0;
        end
        if (i_cmd.step && !o_sts.scan_done) begin
            r_idx <= r_idx + CW'(1);
            if (!r_op) begin
                if (!w_cur_used && !r_found) begin
                    r_found <= 1'b1;
                    r_hit   <= w_i;
                end
                if (w_cur_used && w_end > r_va) r_va <= w_end_up;
            end else if (!r_found && w_cur_used && r_addr >= m_start[w_i]
                         && r_addr < w_end) begin
                r_found <= 1'b1;
                r_hit   <= w_i;
            end
        end
        if (i_cmd.commit) begin
            if (!r_op && r_found && !r_len_ovf) begin
                o_status <= ST_OK;
                o_region_address <= r_va;
                o_range_end <= '0;
                o_slot <= 4'(r_hit);
                o_page_action <= PA_NONE;
                o_entry_file <= r_fh;
                o_entry_file_offset <= r_off;
                o_take_file_ref <= !r_anon;
                o_release_file <= 1'b0;
                m_start[r_hit] <= r_va;
                m_len[r_hit]   <= r_alen;
                m_prot[r_hit]  <= r_prot;
                m_flags[r_hit] <= r_flags;
                m_hasf[r_hit]  <= !r_anon;
                m_file[r_hit]  <= r_fh;
                m_off[r_hit]   <= r_off;
            end else if (r_op && r_found) begin
                o_status <= ST_OK;
                o_region_address <= r_addr;
                o_range_end <= u_end;
                o_slot <= 4'(r_hit);
                o_page_action <= u_act;
                o_entry_file <= u_hf ? m_file[r_hit] : 8'd0;
                o_entry_file_offset <= m_off[r_hit];
                o_take_file_ref <= 1'b0;
                o_release_file <= u_whole && u_hf;
                if (!u_whole && r_addr == u_start) begin
                    m_start[r_hit] <= u_end;
                    m_len[r_hit]   <= m_len[r_hit] - u_cut[31:0];
                    m_off[r_hit]   <= m_off[r_hit] + u_cut[31:0];
                end else if (!u_whole && u_end == u_vend) begin
                    m_len[r_hit]   <= m_len[r_hit] - u_cut[31:0];
                end
            end else begin
                o_status <= u_fail;
                o_region_address <= '0;
                o_range_end <= '0;
                o_slot <= '0;
                o_page_action <= PA_NONE;
                o_entry_file <= '0;
                o_entry_file_offset <= '0;
                o_take_file_ref <= 1'b0;
                o_release_file <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.commit && r_found) begin
            if (!r_op && !r_len_ovf) r_used[r_hit] <= 1'b1;
            else if (r_op && u_whole) r_used[r_hit] <= 1'b0;
        end
    end

`ifndef SYNTH
    a_hit_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && r_op && r_found) |-> r_used[r_hit]) else $error("hit slot unused");
    a_free_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_op && r_found) |-> !r_used[r_hit]) else $error("map slot used");
    a_va_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && !r_op) |-> r_va[PB-1:0] == '0) else $error("unaligned placement");
`endif
endmodule
`default_nettype wire

### rtl/core/mmap_region_table.sv
`default_nettype none
// channel | handshake             | payload
// in      | i_in_valid/o_in_ready | i_operation .. i_file_offset
// out     | o_out_valid/i_out_ready | o_status .. o_release_file
// An item is scanned one slot of the table per cycle, then the table is
// updated; an item that fails its argument checks skips the scan.
// One item at a time; the next is taken once the result has been taken.
// Synchronous active-low reset clears the slot-in-use bits and control.
module mmap_region_table #(
    parameter int SLOTS      = 16,
    parameter int PAGE_BYTES = 4096
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_operation,
    input  wire logic [63:0] i_address,
    input  wire logic [31:0] i_length,
    input  wire logic [2:0]  i_protection,
    input  wire logic [2:0]  i_map_flags,
    input  wire logic        i_no_descriptor,
    input  wire logic        i_file_present,
    input  wire logic        i_file_readable,
    input  wire logic        i_file_writable,
    input  wire logic [7:0]  i_file_handle,
    input  wire logic [31:0] i_file_offset,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_status,
    output logic [63:0]      o_region_address,
    output logic [63:0]      o_range_end,
    output logic [3:0]       o_slot,
    output logic [1:0]       o_page_action,
    output logic [7:0]       o_entry_file,
    output logic [31:0]      o_entry_file_offset,
    output logic             o_take_file_ref,
    output logic             o_release_file
);
    import mrt_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    mrt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .o_cmd(w_cmd), .i_sts(w_sts)
    );

    mrt_dp #(.SLOTS(SLOTS), .PAGE_BYTES(PAGE_BYTES)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts),
        .i_operation, .i_address, .i_length, .i_protection, .i_map_flags,
        .i_no_descriptor, .i_file_present, .i_file_readable, .i_file_writable,
        .i_file_handle, .i_file_offset,
        .o_status, .o_region_address, .o_range_end, .o_slot, .o_page_action,
        .o_entry_file, .o_entry_file_offset, .o_take_file_ref, .o_release_file
    );
endmodule
`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import mrt_pkg::*;

    typedef struct {
        bit        op;
        bit [63:0] addr;
        bit [31:0] len;
        bit [2:0]  prot;
        bit [2:0]  flags;
        bit        no_desc;
        bit        present;
        bit        readable;
        bit        writable;
        bit [7:0]  handle;
        bit [31:0] offset;
    } request_t;

    typedef struct {
        t_status   status;
        bit [63:0] region_address;
        bit [63:0] range_end;
        bit [3:0]  slot;
        bit [1:0]  action;
        bit [7:0]  file;
        bit [31:0] file_offset;
        bit        take_ref;
        bit        release_file;
    } region_word_t;

    localparam bit OP_MAP   = 1'b0;
    localparam bit OP_UNMAP = 1'b1;
    localparam int NSLOTS   = 16;
    localparam int PAGE     = 4096;

    class region_scoreboard;
        bit        used[NSLOTS];
        bit [63:0] start[NSLOTS];
        bit [31:0] size[NSLOTS];
        bit [2:0]  prot[NSLOTS];
        bit [2:0]  flags[NSLOTS];
        bit        has_file[NSLOTS];
        bit [7:0]  file[NSLOTS];
        bit [31:0] offs[NSLOTS];
        region_word_t expected_q[$];
        int errors;

        function bit [63:0] page_up(bit [63:0] v);
            return (v[11:0] != 0) ? ((v | 64'hfff) + 64'd1) : v;
        endfunction

        function void map_region(request_t q, ref region_word_t e);
            bit anon;
            bit [2:0] fl;
            bit [31:0] off;
            int idx;
            bit [63:0] alen, va, rend;
            anon = q.no_desc || q.flags[2];
            fl = q.flags;
            off = q.offset;
            idx = NSLOTS;
            if ($signed(q.len) <= 0) begin
                e.status = ST_BAD_LEN;
                return;
            end
            if (anon) begin
                fl = fl | FL_ANON;
                off = 0;
            end else begin
                if (q.offset[11:0] != 0) begin
                    e.status = ST_UNALIGNED;
                    return;
                end
                if (!q.present) begin
                    e.status = ST_NO_FILE;
                    return;
                end
                if (q.prot[0] && !q.readable) begin
                    e.status = ST_UNREADABLE;
                    return;
                end
                if (q.prot[1] && fl[0] && !q.writable) begin
                    e.status = ST_UNWRITABLE;
                    return;
                end
            end
            for (int i = NSLOTS - 1; i >= 0; i--)
                if (!used[i]) idx = i;
            if (idx == NSLOTS) begin
                e.status = ST_FULL;
                return;
            end
            alen = page_up({32'd0, q.len});
            if (alen > 64'h7fff_ffff) begin
                e.status = ST_BAD_LEN;
                return;
            end
            va = MAP_BASE;
            for (int i = 0; i < NSLOTS; i++) begin
                if (used[i]) begin
                    rend = start[i] + size[i];
                    if (rend > va) va = page_up(rend);
                end
            end
            used[idx] = 1;
            start[idx] = va;
            size[idx] = alen[31:0];
            prot[idx] = q.prot;
            flags[idx] = fl;
            has_file[idx] = !anon;
            file[idx] = anon ? 8'd0 : q.handle;
            offs[idx] = off;
            e.status = ST_OK;
            e.region_address = va;
            e.slot = idx[3:0];
            e.file = file[idx];
            e.file_offset = off;
            e.take_ref = !anon;
        endfunction

        function void unmap_range(request_t q, ref region_word_t e);
            int hit;
            bit [63:0] vend, rl, rend, cut;
            hit = NSLOTS;
            if ($signed(q.len) <= 0 || q.addr[11:0] != 0) begin
                e.status = ST_BAD_UNMAP;
                return;
            end
            for (int i = NSLOTS - 1; i >= 0; i--)
                if (used[i] && q.addr >= start[i] && q.addr < start[i] + size[i]) hit = i;
            if (hit == NSLOTS) begin
                e.status = ST_NOT_MAPPED;
                return;
            end
            vend = start[hit] + size[hit];
            rl = page_up({32'd0, q.len});
            rend = (rl >= vend - q.addr) ? vend : q.addr + rl;
            e.status = ST_OK;
            e.region_address = q.addr;
            e.range_end = rend;
            e.slot = hit[3:0];
            if ((flags[hit] & FL_SHARED) != 0 && (prot[hit] & PR_WRITE) != 0 && has_file[hit])
                e.action = PA_WBACK;
            else if ((flags[hit] & FL_PRIVATE) != 0 && has_file[hit])
                e.action = PA_DROP;
            else if ((flags[hit] & FL_ANON) != 0)
                e.action = PA_FREE;
            else
                e.action = PA_NONE;
            e.file = has_file[hit] ? file[hit] : 8'd0;
            e.file_offset = offs[hit];
            cut = rend - q.addr;
            if (q.addr == start[hit] && rend == vend) begin
                used[hit] = 0;
                e.release_file = has_file[hit];
            end else if (q.addr == start[hit]) begin
                start[hit] = rend;
                size[hit] = size[hit] - cut[31:0];
                offs[hit] = offs[hit] + cut[31:0];
            end else if (rend == vend) begin
                size[hit] = size[hit] - cut[31:0];
            end
        endfunction

        function void note_input(request_t q);
            region_word_t e;
            e = '{status: ST_OK, default: 0};
            if (q.op == OP_UNMAP) unmap_range(q, e);
            else map_region(q, e);
            expected_q.push_back(e);
        endfunction

        task report(string fld, bit [63:0] want, bit [63:0] got);
            $display("%0t mismatch %s: expected %h got %h", $realtime, fld, want, got);
            errors++;
        endtask

        task check_result(region_word_t r);
            region_word_t e;
            if (expected_q.size() == 0) begin
                report("unexpected word", 0, r.status);
                return;
            end
            e = expected_q.pop_front();
            if (r.status != e.status) report("status", e.status, r.status);
            if (r.region_address != e.region_address)
                report("region_address", e.region_address, r.region_address);
            if (r.range_end != e.range_end) report("range_end", e.range_end, r.range_end);
            if (r.slot != e.slot) report("slot", e.slot, r.slot);
            if (r.action != e.action) report("page_action", e.action, r.action);
            if (r.file != e.file) report("entry_file", e.file, r.file);
            if (r.file_offset != e.file_offset)
                report("entry_file_offset", e.file_offset, r.file_offset);
            if (r.take_ref != e.take_ref) report("take_file_ref", e.take_ref, r.take_ref);
            if (r.release_file != e.release_file)
                report("release_file", e.release_file, r.release_file);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_ready;
    logic        i_operation = 0;
    logic [63:0] i_address = 0;
    logic [31:0] i_length = 0;
    logic [2:0]  i_protection = 0;
    logic [2:0]  i_map_flags = 0;
    logic        i_no_descriptor = 0;
    logic        i_file_present = 0;
    logic        i_file_readable = 0;
    logic        i_file_writable = 0;
    logic [7:0]  i_file_handle = 0;
    logic [31:0] i_file_offset = 0;
    logic        o_out_valid;
    logic        i_out_ready = 0;
    logic [3:0]  o_status;
    logic [63:0] o_region_address;
    logic [63:0] o_range_end;
    logic [3:0]  o_slot;
    logic [1:0]  o_page_action;
    logic [7:0]  o_entry_file;
    logic [31:0] o_entry_file_offset;
    logic        o_take_file_ref;
    logic        o_release_file;

    mmap_region_table dut (.*);

    region_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // receiver; a non-zero hold_left forces a long hold-off
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        request_t q;
        region_word_t r;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                q = '{i_operation, i_address, i_length, i_protection, i_map_flags,
                      i_no_descriptor, i_file_present, i_file_readable, i_file_writable,
                      i_file_handle, i_file_offset};
                sb.note_input(q);
            end
            if (o_out_valid && i_out_ready) begin
                r = '{t_status'(o_status), o_region_address, o_range_end, o_slot,
                      o_page_action, o_entry_file, o_entry_file_offset, o_take_file_ref,
                      o_release_file};
                sb.check_result(r);
            end
        end
    end

    task send_word(request_t q);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_operation <= q.op;
        i_address <= q.addr;
        i_length <= q.len;
        i_protection <= q.prot;
        i_map_flags <= q.flags;
        i_no_descriptor <= q.no_desc;
        i_file_present <= q.present;
        i_file_readable <= q.readable;
        i_file_writable <= q.writable;
        i_file_handle <= q.handle;
        i_file_offset <= q.offset;
        do @(negedge i_clk); while (!o_in_ready);
        @(posedge i_clk);
    endtask

    function request_t req(bit op, bit [63:0] a, bit [31:0] l, bit [2:0] p, bit [2:0] f,
                           bit nd, bit fp, bit fr, bit fw, bit [7:0] h, bit [31:0] o);
        return '{op, a, l, p, f, nd, fp, fr, fw, h, o};
    endfunction

    function request_t random_request();
        request_t q;
        int pick, s, pages, live[$];
        pick = $urandom_range(99);
        q = req($urandom, {$urandom, $urandom}, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom, $urandom);
        for (int i = 0; i < NSLOTS; i++)
            if (sb.used[i]) live.push_back(i);
        if (pick < 40) begin
            q.op = OP_MAP;
            q.len = $urandom_range(1, 8 * PAGE);
            q.present = 1;
            q.readable = 1;
            q.writable = $urandom_range(3) != 0;
            q.offset[11:0] = 0;
            q.no_desc = $urandom_range(3) == 0;
        end else if (pick < 80 && live.size() != 0) begin
            s = live[$urandom_range(live.size() - 1)];
            pages = sb.size[s] / PAGE;
            q.op = OP_UNMAP;
            q.addr = sb.start[s] + 64'(PAGE) * $urandom_range(pages - 1);
            q.len = ($urandom_range(9) == 0) ? {1'b0, q.len[30:0]}
                                              : $urandom_range(1, (pages + 1) * PAGE);
        end
        return q;
    endfunction

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        request_t d[$];
        int waited;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        d.push_back(req(OP_MAP, 0, 0, 1, 2, 0, 1, 1, 1, 1, 0));
        d.push_back(req(OP_MAP, 0, 32'h8000_0000, 1, 2, 0, 1, 1, 1, 1, 0));
        d.push_back(req(OP_MAP, 0, 100, 1, 2, 0, 1, 1, 1, 1, 32'h800));
        d.push_back(req(OP_MAP, 0, 100, 1, 2, 0, 0, 1, 1, 1, 0));
        d.push_back(req(OP_MAP, 0, 100, 1, 2, 0, 1, 0, 1, 1, 0));
        d.push_back(req(OP_MAP, 0, 100, 3, 1, 0, 1, 1, 0, 1, 0));
        d.push_back(req(OP_MAP, 0, 32'h7fff_ffff, 1, 2, 0, 1, 1, 1, 1, 0));
        d.push_back(req(OP_MAP, 0, 32'h7fff_f000, 7, 1, 0, 1, 1, 1, 8'hff, 32'h8000_0000));
        d.push_back(req(OP_MAP, 0, 1, 3, 2, 1, 0, 0, 0, 8'h55, 32'h123));
        d.push_back(req(OP_MAP, 0, 32'h3000, 1, 2, 0, 1, 1, 0, 8'h0f, 32'h7fff_f000));
        d.push_back(req(OP_UNMAP, 64'hdffff000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        d.push_back(req(OP_UNMAP, 64'hdffff800, 4, 0, 0, 0, 0, 0, 0, 0, 0));
        d.push_back(req(OP_UNMAP, 64'hffff_ffff_ffff_f000, 4, 0, 0, 0, 0, 0, 0, 0, 0));
        d.push_back(req(OP_UNMAP, 64'he0001000, 32'h1000, 0, 0, 0, 0, 0, 0, 0, 0));
        d.push_back(req(OP_UNMAP, 64'he0000000, 1, 0, 0, 0, 0, 0, 0, 0, 0));
        d.push_back(req(OP_UNMAP, 64'he0002000, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 0, 0));
        d.push_back(req(OP_UNMAP, 64'he0001000, 32'h1000, 0, 0, 0, 0, 0, 0, 0, 0));
        d.push_back(req(OP_UNMAP, 64'hdffff000, 32'h1000, 0, 0, 0, 0, 0, 0, 0, 0));
        d.push_back(req(OP_UNMAP, 64'h60000000, 32'h7fff_f000, 0, 0, 0, 0, 0, 0, 0, 0));
        foreach (d[k]) send_word(d[k]);
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 50 : (ph == 3) ? 24 : 0;
            recv_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 24 : 0;
            for (int n = 0; n < 375; n++) begin
                if (ph == 0 && n == 100) hold_left = 400;
                send_word(random_request());
            end
        end
        i_in_valid <= 0;
        waited = 0;
        while (sb.expected_q.size() != 0 && waited < 100_000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/mrt_pkg.sv
rtl/core/mrt_ctrl.sv
rtl/core/mrt_dp.sv
rtl/core/mmap_region_table.sv
bench/testbench.sv
